@@ rtl/beta_digit_polynomial_phase_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef BETA_DIGIT_POLYNOMIAL_PHASE_DEFINES_SVH
`define BETA_DIGIT_POLYNOMIAL_PHASE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BDPP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define BDPP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BDPP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BDPP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/bdpp_pkg.sv @@
// ----------------------------------------------------------------------------
// bdpp_pkg
// Shared types and constants of the beta-digit polynomial phase block.
// ----------------------------------------------------------------------------
package bdpp_pkg;

    localparam int unsigned MAX_ROW = 4096;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_HALF_BETA   = 3'd0,
        REG_ROW_IMAG    = 3'd1,
        REG_VIEW_CENTER = 3'd2,
        REG_VIEW_WIDTH  = 3'd3,
        REG_ROW_LENGTH  = 3'd4
    } reg_index_t;

    // classified pixel, front to back
    typedef struct packed {
        logic signed [17:0] x;
        logic               in_disk;
    } item_t;

    typedef struct packed {
        logic        [12:0] row_length;
        logic signed [18:0] view_center;
        logic        [18:0] view_width;
        logic signed [17:0] row_imag;
    } front_cfg_t;

    typedef struct packed {
        logic        [16:0] half_beta;
        logic signed [17:0] row_imag;
        logic               beta_changed;
    } back_cfg_t;

    // CORDIC angles in 2^-20 turn
    function automatic logic signed [21:0] cordic_angle(input logic [3:0] k);
        logic signed [21:0] a;
        case (k)
            4'd0:    a = 22'sd131072;
            4'd1:    a = 22'sd77376;
            4'd2:    a = 22'sd40884;
            4'd3:    a = 22'sd20753;
            4'd4:    a = 22'sd10417;
            4'd5:    a = 22'sd5213;
            4'd6:    a = 22'sd2607;
            4'd7:    a = 22'sd1304;
            4'd8:    a = 22'sd652;
            4'd9:    a = 22'sd326;
            4'd10:   a = 22'sd163;
            4'd11:   a = 22'sd81;
            4'd12:   a = 22'sd41;
            4'd13:   a = 22'sd20;
            4'd14:   a = 22'sd10;
            default: a = 22'sd5;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/bdpp_ram.sv @@
// ----------------------------------------------------------------------------
// bdpp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bdpp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 80
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/bdpp_queue.sv @@
// ----------------------------------------------------------------------------
// bdpp_queue
// Two-entry queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
module bdpp_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  bdpp_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output bdpp_pkg::item_t head_item
);
    import bdpp_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign empty     = (count_reg == 2'd0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end
endmodule

@@ rtl/bdpp_front.sv @@
// ----------------------------------------------------------------------------
// bdpp_front
// Maps a pixel index to x by serial division and scaling; disk test.
// ----------------------------------------------------------------------------
module bdpp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bdpp_pkg::front_cfg_t cfg,
    input  logic                 start,
    input  logic [11:0]          pixel_index,
    output logic                 busy,
    output logic                 push,
    output bdpp_pkg::item_t      push_item,
    input  logic                 full
);
    import bdpp_pkg::*;

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_DIV  = 5'b00010,
        F_MUL  = 5'b00100,
        F_SQ   = 5'b01000,
        F_PUSH = 5'b10000
    } fstate_t;

    fstate_t            state_reg;
    logic [28:0]        num_reg;      // numerator, then quotient
    logic [14:0]        rem_reg;
    logic [4:0]         cnt_reg;
    logic signed [50:0] prod_reg;
    logic signed [17:0] x_reg;
    logic               rng_ok_reg;
    logic signed [36:0] sq_reg;

    logic [12:0]        n_clamp;
    logic [13:0]        den;
    logic [14:0]        trial;
    logic               q_bit;
    logic signed [30:0] t_val;
    logic signed [34:0] x_full;
    logic signed [17:0] x_trunc;
    logic               x_ok, y_ok;

    always_comb
    begin
        if (cfg.row_length == 13'd0)
        begin
            n_clamp = 13'd1;
        end
        else if ({4'd0, cfg.row_length} > 17'(MAX_ROW))
        begin
            n_clamp = 13'(MAX_ROW);
        end
        else
        begin
            n_clamp = cfg.row_length;
        end
    end

    assign den   = {n_clamp, 1'b0};
    assign trial = {rem_reg[13:0], num_reg[28]};
    assign q_bit = (trial >= {1'b0, den});

    assign t_val   = $signed({2'b00, num_reg}) - 31'sd32768 - 31'(cfg.view_center);
    assign x_full  = prod_reg[50:16];
    assign x_trunc = x_full[17:0];
    assign x_ok    = (x_full <= 35'sd65536) && (x_full >= -35'sd65536);
    assign y_ok    = (cfg.row_imag <= 18'sd65536) && (cfg.row_imag >= -18'sd65536);

    assign busy              = (state_reg != F_IDLE);
    assign push              = (state_reg == F_PUSH) && !full;
    assign push_item.x       = x_reg;
    assign push_item.in_disk = rng_ok_reg && (sq_reg <= 37'sd4294967296);

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                num_reg <= {pixel_index, 1'b1, 16'd0};
                rem_reg <= 15'd0;
            end
            F_DIV:
            begin
                rem_reg <= q_bit ? (trial - {1'b0, den}) : trial;
                num_reg <= {num_reg[27:0], q_bit};
            end
            F_MUL:
            begin
                prod_reg <= t_val * $signed({1'b0, cfg.view_width});
            end
            F_SQ:
            begin
                x_reg      <= x_trunc;
                rng_ok_reg <= x_ok && y_ok;
                sq_reg     <= x_trunc * x_trunc + cfg.row_imag * cfg.row_imag;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= 5'd0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    cnt_reg <= 5'd0;
                    if (start)
                    begin
                        state_reg <= F_DIV;
                    end
                end
                F_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd28)
                    begin
                        state_reg <= F_MUL;
                    end
                end
                F_MUL:  state_reg <= F_SQ;
                F_SQ:   state_reg <= F_PUSH;
                F_PUSH:
                begin
                    if (!full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end
endmodule

@@ rtl/bdpp_back.sv @@
// ----------------------------------------------------------------------------
// bdpp_back
// Digit build, power-series accumulation and CORDIC phase of one pixel.
// ----------------------------------------------------------------------------
`include "beta_digit_polynomial_phase_defines.svh"

module bdpp_back #(
    parameter int SEQ_LENGTH    = 80,
    parameter int SUM_FRAC_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bdpp_pkg::back_cfg_t cfg,
    input  logic                empty,
    input  bdpp_pkg::item_t     head_item,
    output logic                pop,
    output logic                done,
    output logic [15:0]         phase,
    output logic                inside_disk
);
    import bdpp_pkg::*;

    localparam int IW = $clog2(SEQ_LENGTH);
    localparam int ZW = SUM_FRAC_BITS + 3;
    localparam int QW = SUM_FRAC_BITS + 8;
    localparam int PW = ZW + 18;
    localparam int CW = QW + 3;
    localparam logic [IW-1:0] LAST = IW'(SEQ_LENGTH - 1);
    localparam logic signed [PW:0] PLIM = (PW+1)'(1) <<< (SUM_FRAC_BITS + 1);
    localparam logic signed [QW:0] SHI  = ((QW+1)'(1) <<< (SUM_FRAC_BITS + 7)) - 1;
    localparam logic signed [QW:0] SLO  = -((QW+1)'(1) <<< (SUM_FRAC_BITS + 7));
    localparam logic signed [ZW-1:0] Z_ONE = ZW'(1) <<< SUM_FRAC_BITS;
    localparam logic signed [QW-1:0] Q_ONE = QW'(1) <<< SUM_FRAC_BITS;
    localparam logic [49:0] MAP_HALF = 50'd1 << 47;

    typedef enum logic [8:0] {
        B_IDLE    = 9'b000000001,
        B_BUILD_A = 9'b000000010,
        B_BUILD_B = 9'b000000100,
        B_MUL_A   = 9'b000001000,
        B_MUL_B   = 9'b000010000,
        B_ACC     = 9'b000100000,
        B_CINIT   = 9'b001000000,
        B_CORDIC  = 9'b010000000,
        B_FIN     = 9'b100000000
    } bstate_t;

    bstate_t              state_reg;
    logic                 digits_ok_reg;
    logic [IW-1:0]        idx_reg;
    logic [3:0]           k_reg;
    logic [49:0]          m_reg;
    logic [42:0]          plo_reg;
    logic signed [17:0]   x_reg;
    logic signed [ZW-1:0] zr_reg, zi_reg;
    logic signed [QW-1:0] qr_reg, qi_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [CW-1:0] re_reg, im_reg;
    logic signed [21:0]   ang_reg;
    logic                 done_reg, inside_reg;
    logic [15:0]          phase_reg;

    logic [49:0]          map_a;
    logic [17:0]          twok;
    logic [42:0]          phi;
    logic [67:0]          map_full;
    logic                 digit_rd;
    logic signed [PW:0]   sr, si, sr_sh, si_sh;
    logic signed [ZW-1:0] zr_new, zi_new;
    logic signed [QW:0]   qdr, qdi;
    logic signed [QW-1:0] qr_new, qi_new;
    logic signed [CW-1:0] cre, cim, dr, di;
    logic signed [21:0]   ang_rnd;

    bdpp_ram #(
        .WIDTH (1),
        .DEPTH (SEQ_LENGTH)
    ) u_digits (
        .clk   (clk),
        .we    (state_reg == B_BUILD_A),
        .waddr (idx_reg),
        .wdata (m_reg > MAP_HALF),
        .raddr (idx_reg),
        .rdata (digit_rd)
    );

    assign map_a    = (m_reg >= MAP_HALF) ? (m_reg - MAP_HALF) : m_reg;
    assign twok     = {cfg.half_beta, 1'b0};
    assign phi      = {18'd0, map_a[49:25]} * {25'd0, twok};
    assign map_full = {phi, 25'd0} + {25'd0, plo_reg};

    // complex product of z and (x + iy), floored and saturated
    assign sr    = p1_reg - p2_reg;
    assign si    = p3_reg + p4_reg;
    assign sr_sh = sr >>> 16;
    assign si_sh = si >>> 16;
    assign zr_new = (sr_sh > PLIM) ? ZW'(PLIM) : ((sr_sh < -PLIM) ? ZW'(-PLIM) : ZW'(sr_sh));
    assign zi_new = (si_sh > PLIM) ? ZW'(PLIM) : ((si_sh < -PLIM) ? ZW'(-PLIM) : ZW'(si_sh));

    assign qdr    = qr_reg - zr_reg;
    assign qdi    = qi_reg - zi_reg;
    assign qr_new = (qdr > SHI) ? QW'(SHI) : ((qdr < SLO) ? QW'(SLO) : QW'(qdr));
    assign qi_new = (qdi > SHI) ? QW'(SHI) : ((qdi < SLO) ? QW'(SLO) : QW'(qdi));

    assign cre = CW'(qr_reg);
    assign cim = CW'(qi_reg);
    assign dr  = im_reg >>> k_reg;
    assign di  = re_reg >>> k_reg;

    assign ang_rnd = ang_reg + 22'sd8;

    assign pop         = (state_reg == B_IDLE) && !empty;
    assign done        = done_reg;
    assign phase       = phase_reg;
    assign inside_disk = inside_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                x_reg   <= head_item.x;
                m_reg   <= {1'b0, cfg.half_beta, 32'd0};
                zr_reg  <= Z_ONE;
                zi_reg  <= '0;
                qr_reg  <= Q_ONE;
                qi_reg  <= '0;
                if (!head_item.in_disk)
                begin
                    phase_reg  <= 16'd0;
                    inside_reg <= 1'b0;
                end
            end
            B_BUILD_A:
            begin
                plo_reg <= map_a[24:0] * twok;
            end
            B_BUILD_B:
            begin
                m_reg <= map_full[65:16];
            end
            B_MUL_A:
            begin
                p1_reg <= zr_reg * x_reg;
                p2_reg <= zi_reg * cfg.row_imag;
            end
            B_MUL_B:
            begin
                p3_reg <= zr_reg * cfg.row_imag;
                p4_reg <= zi_reg * x_reg;
            end
            B_ACC:
            begin
                if (digit_rd)
                begin
                    qr_reg <= qr_new;
                    qi_reg <= qi_new;
                end
                zr_reg <= zr_new;
                zi_reg <= zi_new;
            end
            B_CINIT:
            begin
                inside_reg <= 1'b1;
                phase_reg  <= 16'd32768;
                // left half plane: turn by half a turn first
                if (qr_reg < 0)
                begin
                    re_reg  <= -cre;
                    im_reg  <= -cim;
                    ang_reg <= 22'sd524288;
                end
                else
                begin
                    re_reg  <= cre;
                    im_reg  <= cim;
                    ang_reg <= 22'sd0;
                end
            end
            B_CORDIC:
            begin
                if (im_reg > 0)
                begin
                    re_reg  <= re_reg + dr;
                    im_reg  <= im_reg - di;
                    ang_reg <= ang_reg + cordic_angle(k_reg);
                end
                else
                begin
                    re_reg  <= re_reg - dr;
                    im_reg  <= im_reg + di;
                    ang_reg <= ang_reg - cordic_angle(k_reg);
                end
            end
            B_FIN:
            begin
                phase_reg <= ang_rnd[19:4] + 16'd32768;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            digits_ok_reg <= 1'b0;
            idx_reg       <= '0;
            k_reg         <= 4'd0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg.beta_changed)
            begin
                digits_ok_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    idx_reg <= '0;
                    k_reg   <= 4'd0;
                    if (!empty)
                    begin
                        if (!head_item.in_disk)
                        begin
                            done_reg <= 1'b1;
                        end
                        else if (digits_ok_reg)
                        begin
                            state_reg <= B_MUL_A;
                        end
                        else
                        begin
                            state_reg <= B_BUILD_A;
                        end
                    end
                end
                B_BUILD_A: state_reg <= B_BUILD_B;
                B_BUILD_B:
                begin
                    if (idx_reg == LAST)
                    begin
                        idx_reg       <= '0;
                        digits_ok_reg <= 1'b1;
                        state_reg     <= B_MUL_A;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= B_BUILD_A;
                    end
                end
                B_MUL_A: state_reg <= B_MUL_B;
                B_MUL_B: state_reg <= B_ACC;
                B_ACC:
                begin
                    if (idx_reg == LAST)
                    begin
                        state_reg <= B_CINIT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= B_MUL_A;
                    end
                end
                B_CINIT:
                begin
                    if (qr_reg == 0 && qi_reg == 0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= B_IDLE;
                    end
                    else
                    begin
                        state_reg <= B_CORDIC;
                    end
                end
                B_CORDIC:
                begin
                    k_reg <= k_reg + 4'd1;
                    if (k_reg == 4'd15)
                    begin
                        state_reg <= B_FIN;
                    end
                end
                B_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    `BDPP_ASSERT_IMP(a_outside_zero, clk, rst_n, done_reg && !inside_reg, phase_reg == 16'd0)
    `BDPP_ASSERT_NXT(a_series_end, clk, rst_n, (state_reg == B_ACC) && (idx_reg == LAST), state_reg == B_CINIT)
    `BDPP_ASSERT_IMP(a_digits_valid, clk, rst_n, state_reg == B_MUL_A, digits_ok_reg)
endmodule

@@ rtl/beta_digit_polynomial_phase.sv @@
// ----------------------------------------------------------------------------
// beta_digit_polynomial_phase
// Phase of the beta-digit polynomial at one pixel of a row.
// ----------------------------------------------------------------------------
// Usage: pulse start with pixel_index while busy is low; the transfer takes
// place at that edge. busy stays high while the front divides (29 steps,
// one quotient bit per cycle), scales and tests the disk, and stays high
// while the two-entry queue to the back is full.
// Each result appears on phase/inside_disk for one cycle with done high.
// Points outside the disk leave the back straight from its idle state.
// Inside points run the power series, one term per pass through MUL_A,
// MUL_B and ACC (set by the two-multiplier complex step), then CORDIC;
// after a change of half_beta the first inside point first rebuilds the
// digit RAM, one digit per build pass (two partial products per map step).
// Configuration: cfg_valid/cfg_index/cfg_data, always ready; write only when
// the block is idle. Index 0 half_beta, 1 row_imag, 2 view_center,
// 3 view_width, 4 row_length; other indexes are ignored.
// Reset sets the registers to their defaults and marks the digits stale.
// Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module beta_digit_polynomial_phase #(
    parameter int SEQ_LENGTH    = 80,
    parameter int SUM_FRAC_BITS = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [11:0] pixel_index,
    output logic        busy,
    output logic        done,
    output logic [15:0] phase,
    output logic        inside_disk,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [18:0] cfg_data
);
    import bdpp_pkg::*;

    logic [16:0]        half_beta_reg;
    logic signed [17:0] row_imag_reg;
    logic signed [18:0] view_center_reg;
    logic [18:0]        view_width_reg;
    logic [12:0]        row_length_reg;
    logic               beta_changed_reg;

    front_cfg_t fcfg;
    back_cfg_t  bcfg;
    item_t      push_item, head_item;
    logic       push, full, pop, empty, front_busy;

    assign cfg_ready = 1'b1;
    assign busy      = front_busy;

    assign fcfg.row_length  = row_length_reg;
    assign fcfg.view_center = view_center_reg;
    assign fcfg.view_width  = view_width_reg;
    assign fcfg.row_imag    = row_imag_reg;

    assign bcfg.half_beta    = half_beta_reg;
    assign bcfg.row_imag     = row_imag_reg;
    assign bcfg.beta_changed = beta_changed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_beta_reg    <= 17'd49152;
            row_imag_reg     <= 18'sd0;
            view_center_reg  <= 19'sd0;
            view_width_reg   <= 19'd131072;
            row_length_reg   <= 13'd1024;
            beta_changed_reg <= 1'b0;
        end
        else
        begin
            beta_changed_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (reg_index_t'(cfg_index))
                    REG_HALF_BETA:
                    begin
                        // digits go stale only on a real change of beta
                        if (cfg_data[16:0] != half_beta_reg)
                        begin
                            beta_changed_reg <= 1'b1;
                        end
                        half_beta_reg <= cfg_data[16:0];
                    end
                    REG_ROW_IMAG:    row_imag_reg    <= $signed(cfg_data[17:0]);
                    REG_VIEW_CENTER: view_center_reg <= $signed(cfg_data);
                    REG_VIEW_WIDTH:  view_width_reg  <= cfg_data;
                    REG_ROW_LENGTH:  row_length_reg  <= cfg_data[12:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    bdpp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (fcfg),
        .start       (start),
        .pixel_index (pixel_index),
        .busy        (front_busy),
        .push        (push),
        .push_item   (push_item),
        .full        (full)
    );

    bdpp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head_item (head_item)
    );

    bdpp_back #(
        .SEQ_LENGTH    (SEQ_LENGTH),
        .SUM_FRAC_BITS (SUM_FRAC_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (bcfg),
        .empty       (empty),
        .head_item   (head_item),
        .pop         (pop),
        .done        (done),
        .phase       (phase),
        .inside_disk (inside_disk)
    );
endmodule

@@ verif/beta_digit_polynomial_phase_tb.sv @@
// ----------------------------------------------------------------------------
// beta_digit_polynomial_phase_tb
// Drives pixel indexes through the phase block under several view and beta
// settings, predicts phase and disk flag per pixel and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module beta_digit_polynomial_phase_tb;

    import bdpp_pkg::*;

    localparam int SEQ_LEN   = 80;
    localparam int FRAC_BITS = 24;
    localparam int ROW_MAX   = 4096;
    localparam int LIMIT     = 4000000;

    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [15:0] phase;
        logic        in_disk;
    } pixel_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic [11:0] pixel_index;
    logic        busy;
    logic        done;
    logic [15:0] phase;
    logic        inside_disk;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [18:0] cfg_data;

    // model state
    logic [16:0]        m_half_beta;
    logic signed [17:0] m_row_imag;
    logic signed [18:0] m_view_center;
    logic [18:0]        m_view_width;
    logic [12:0]        m_row_length;
    bit                 m_digits [SEQ_LEN];
    bit                 m_digits_ok;

    logic [11:0]   pixel_queue [$];
    pixel_result_t expected_results [$];
    int            send_idle_pct;
    int            mismatches;
    int            results_seen;
    int            cycle_count;
    int            configs_done;

    beta_digit_polynomial_phase i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .pixel_index (pixel_index),
        .busy        (busy),
        .done        (done),
        .phase       (phase),
        .inside_disk (inside_disk),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint unsigned scale_by_2k(longint unsigned a, longint unsigned b);
        return (a >> 16) * b + (((a & 64'hFFFF) * b) >> 16);
    endfunction

    task automatic rebuild_digits();
        longint unsigned m;
        longint unsigned twok;
        longint unsigned half;
        m    = longint'(m_half_beta) << 32;
        twok = 2 * longint'(m_half_beta);
        half = 64'd1 << 47;
        for (int i = 0; i < SEQ_LEN; i++)
        begin
            m_digits[i] = (m > half);
            if (m >= half)
                m = scale_by_2k(m - half, twok);
            else
                m = scale_by_2k(m, twok);
            m &= (64'd1 << 50) - 1;
        end
        m_digits_ok = 1'b1;
    endtask

    function automatic logic [15:0] turn_of(longint re, longint im);
        longint ang;
        longint dr;
        longint di;
        ang = 0;
        if (re == 0 && im == 0)
            return 16'd32768;
        if (re < 0)
        begin
            re  = -re;
            im  = -im;
            ang = 64'd1 << 19;
        end
        for (int i = 0; i < 16; i++)
        begin
            dr = floor_shift(im, i);
            di = floor_shift(re, i);
            if (im > 0)
            begin
                re  += dr;
                im  -= di;
                ang += longint'(bdpp_pkg::cordic_angle(4'(i)));
            end
            else
            begin
                re  -= dr;
                im  += di;
                ang -= longint'(bdpp_pkg::cordic_angle(4'(i)));
            end
        end
        ang = floor_shift(ang + 8, 4);
        return 16'(ang + 32768);
    endfunction

    task automatic predict_pixel(input logic [11:0] j, output pixel_result_t r);
        longint one;
        longint n;
        longint frac;
        longint x;
        longint y;
        longint zr;
        longint zi;
        longint qr;
        longint qi;
        longint nr;
        longint ni;
        one = 64'd1 << FRAC_BITS;
        if (!m_digits_ok)
            rebuild_digits();
        n = m_row_length;
        if (n == 0)
            n = 1;
        if (n > ROW_MAX)
            n = ROW_MAX;
        frac = ((2 * longint'(j) + 1) << 16) / (2 * n);
        x = floor_shift((frac - 32768 - longint'(m_view_center)) * longint'(m_view_width), 16);
        y = m_row_imag;
        if (x > 65536 || x < -65536 || y > 65536 || y < -65536 ||
            x * x + y * y > (64'd1 << 32))
        begin
            r.phase   = 16'd0;
            r.in_disk = 1'b0;
            return;
        end
        zr = one;
        zi = 0;
        qr = one;
        qi = 0;
        for (int i = 0; i < SEQ_LEN; i++)
        begin
            if (m_digits[i])
            begin
                qr = clip(qr - zr, -(one * 128), one * 128 - 1);
                qi = clip(qi - zi, -(one * 128), one * 128 - 1);
            end
            nr = floor_shift(zr * x - zi * y, 16);
            ni = floor_shift(zr * y + zi * x, 16);
            zr = clip(nr, -2 * one, 2 * one);
            zi = clip(ni, -2 * one, 2 * one);
        end
        r.phase   = turn_of(qr, qi);
        r.in_disk = 1'b1;
    endtask

    task automatic model_write(input logic [2:0] idx, input logic [18:0] data);
        case (idx)
            REG_HALF_BETA:
            begin
                if (data[16:0] != m_half_beta)
                    m_digits_ok = 1'b0;
                m_half_beta = data[16:0];
            end
            REG_ROW_IMAG:    m_row_imag    = data[17:0];
            REG_VIEW_CENTER: m_view_center = data;
            REG_VIEW_WIDTH:  m_view_width  = data;
            REG_ROW_LENGTH:  m_row_length  = data[12:0];
            default: ;
        endcase
    endtask

    // register write, only with the block idle
    task automatic write_reg(input logic [2:0] idx, input logic [18:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_write(idx, data);
        configs_done++;
    endtask

    task automatic wait_idle();
        while (pixel_queue.size() != 0 || expected_results.size() != 0 || start || busy)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_view(logic [16:0] hb, logic signed [17:0] yi,
                            logic signed [18:0] ctr, logic [18:0] wid, logic [12:0] len);
        write_reg(REG_HALF_BETA, 19'(hb));
        write_reg(REG_ROW_IMAG, 19'(yi));
        write_reg(REG_VIEW_CENTER, ctr);
        write_reg(REG_VIEW_WIDTH, wid);
        write_reg(REG_ROW_LENGTH, 19'(len));
    endtask

    // one setting: mostly in-row pixels, a few past the row
    task automatic run_phase(int count, int idle_pct);
        int n;
        n = (m_row_length == 0) ? 1 : int'(m_row_length);
        send_idle_pct = idle_pct;
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(9) == 0 || n > ROW_MAX)
                pixel_queue.push_back(12'($urandom));
            else
                pixel_queue.push_back(12'($urandom_range(n - 1)));
        end
        wait_idle();
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start       <= 1'b0;
            pixel_index <= '0;
        end
        else
        begin
            pixel_result_t r;
            if (start && !busy)
            begin
                predict_pixel(pixel_index, r);
                expected_results.push_back(r);
            end
            if (!(start && busy))
            begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    start       <= 1'b1;
                    pixel_index <= pixel_queue.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && done)
        begin
            pixel_result_t e;
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result phase=%0d inside=%0d", phase, inside_disk);
            end
            else
            begin
                e = expected_results.pop_front();
                if (e.phase !== phase || e.in_disk !== inside_disk)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp phase=%0d inside=%0d, got phase=%0d inside=%0d",
                                 e.phase, e.in_disk, phase, inside_disk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count >= LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[beta_digit_polynomial_phase] ERROR");
            $finish;
        end
    end

    initial
    begin
        start         = 1'b0;
        pixel_index   = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        send_idle_pct = 0;
        mismatches    = 0;
        results_seen  = 0;
        cycle_count   = 0;
        configs_done  = 0;
        m_half_beta   = 17'd49152;
        m_row_imag    = '0;
        m_view_center = '0;
        m_view_width  = 19'd131072;
        m_row_length  = 13'd1024;
        m_digits_ok   = 1'b0;
        foreach (m_digits[i])
            m_digits[i] = 1'b0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, field extremes, centre pixels
        pixel_queue.push_back(12'd0);
        pixel_queue.push_back(12'd511);
        pixel_queue.push_back(12'd512);
        pixel_queue.push_back(12'd1023);
        pixel_queue.push_back(12'd4095);
        pixel_queue.push_back(12'hAAA);
        pixel_queue.push_back(12'h555);
        wait_idle();
        // zero width: every point at origin, q = 1 - d0 gives zero sum or axis cases
        set_view(17'd32768, 18'sd0, 19'sd0, 19'd0, 13'd0);
        pixel_queue.push_back(12'd0);
        pixel_queue.push_back(12'd4095);
        wait_idle();
        set_view(17'd65536, 18'sd0, 19'sd0, 19'd0, 13'd1);
        pixel_queue.push_back(12'd0);
        wait_idle();
        // row length above the maximum, out-of-range beta, ignored index
        write_reg(REG_UNUSED, 19'h7FFFF);
        set_view(17'h1FFFF, 18'sd65536, 19'sd131072, 19'd262144, 13'h1FFF);
        pixel_queue.push_back(12'd4095);
        pixel_queue.push_back(12'd0);
        wait_idle();
        set_view(17'd0, -18'sd65536, -19'sd131072, 19'h7FFFF, 13'd4096);
        pixel_queue.push_back(12'd2048);
        wait_idle();
        set_view(17'd40000, 18'sd30000, 19'sd0, 19'd131072, 13'd8);
        for (int k = 0; k < 8; k++)
            pixel_queue.push_back(12'(k));
        wait_idle();

        // random settings with varied idling
        for (int p = 0; p < 12; p++)
        begin
            int idle;
            case (p % 4)
                0: idle = 0;
                1: idle = 85;
                2: idle = 29;
                default: idle = 50;
            endcase
            set_view(17'($urandom_range(65536, 32768)),
                     18'($urandom_range(131072) - 65536),
                     19'($urandom_range(40000) - 20000),
                     19'($urandom_range(262144)),
                     13'($urandom_range(4096, 1)));
            if (p % 5 == 4)
                write_reg(REG_HALF_BETA, 19'($urandom));
            if (p == 11)
                write_reg(REG_ROW_IMAG, 19'($urandom));
            run_phase(72, idle);
        end

        $display("%0d pixel results checked over %0d register writes, %0d mismatches",
                 results_seen, configs_done, mismatches);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("[beta_digit_polynomial_phase] OK");
        else
            $display("[beta_digit_polynomial_phase] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bdpp_pkg.sv
rtl/bdpp_ram.sv
rtl/bdpp_queue.sv
rtl/bdpp_front.sv
rtl/bdpp_back.sv
rtl/beta_digit_polynomial_phase.sv
verif/beta_digit_polynomial_phase_tb.sv
